// File: design/lr_pkg.sv
// Shared constants and control types for the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package lr_pkg;

  // Coordinate width of every endpoint and pixel field
  localparam int CW = 6;
  // Signed width of the decision variable: spans about +/- 4 * grid
  localparam int DW = CW + 3;
  // Default grid size along either axis
  localparam int GRID_SIZE_DEF = 64;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // latch a new segment and set up the stepping state
    logic step;  // move the current pixel to the output register and advance
  } lr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;  // current pixel is the final one of the segment
  } lr_stat_t;

endpackage
`default_nettype wire

// File: design/lr_ctrl.sv
// Controller for the line rasterizer: segment sequencing and output valid.
`timescale 1ns / 1ps
`default_nettype none
module lr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output lr_pkg::lr_cmd_t       cmd,
  input  wire lr_pkg::lr_stat_t stat
);
  import lr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } lr_state_t;

  lr_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;

  // Issue commands: take a segment when idle, step when the output slot frees up
  always_comb begin
    cmd.load = (state_r == ST_IDLE) && in_tvalid;
    cmd.step = (state_r == ST_RUN) && (!out_valid_r || out_tready);
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state: run until the final pixel has been moved out
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.step && stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Fill the output slot on a step, empty it when the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/lr_dp.sv
// Datapath for the line rasterizer: endpoint setup, midpoint stepping, output register.
`timescale 1ns / 1ps
`default_nettype none
module lr_dp #(
  parameter int GRID_SIZE = lr_pkg::GRID_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic [lr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire lr_pkg::lr_cmd_t               cmd,
  output lr_pkg::lr_stat_t                   stat,
  output logic [lr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);
  import lr_pkg::*;

  localparam logic [CW-1:0] MAX_C = CW'(GRID_SIZE - 1);

  function automatic logic [CW-1:0] clamp_c(input logic [CW-1:0] v);
    clamp_c = (v > MAX_C) ? MAX_C : v;
  endfunction

  function automatic logic signed [DW-1:0] sx(input logic [CW-1:0] v);
    sx = signed'({{(DW - CW){1'b0}}, v});
  endfunction

  // Stepping state
  logic [CW-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic [CW-1:0]        dx_r, dx_nxt, ady_r, ady_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  logic                 steep_r, steep_nxt, yneg_r, yneg_nxt;
  // Output register
  logic [CW-1:0]        px_r, py_r;
  logic                 plast_r;

  // Setup terms from the incoming beat
  logic [CW-1:0]        xa, ya, xb, yb, x0, y0, x1, y1;
  logic [CW-1:0]        sdx, sady;
  logic                 sneg, ssteep;
  // Step terms
  logic [CW-1:0]        minor, major;
  logic                 d_pos;

  assign stat.last = (cnt_r == '0);

  // Clamp, order endpoints so x rises, classify slope
  always_comb begin
    xa     = clamp_c(in_tdata[CW-1:0]);
    ya     = clamp_c(in_tdata[2*CW-1:CW]);
    xb     = clamp_c(in_tdata[3*CW-1:2*CW]);
    yb     = clamp_c(in_tdata[4*CW-1:3*CW]);
    x0     = (xa > xb) ? xb : xa;
    y0     = (xa > xb) ? yb : ya;
    x1     = (xa > xb) ? xa : xb;
    y1     = (xa > xb) ? ya : yb;
    sdx    = x1 - x0;
    sneg   = (y1 < y0);
    sady   = sneg ? (y0 - y1) : (y1 - y0);
    ssteep = (sady > sdx);
  end

  // Load the setup on cmd.load; on a step advance along the major axis, the minor axis when the decision is positive
  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    dx_nxt    = dx_r;
    ady_nxt   = ady_r;
    cnt_nxt   = cnt_r;
    d_nxt     = d_r;
    steep_nxt = steep_r;
    yneg_nxt  = yneg_r;
    minor     = steep_r ? dx_r : ady_r;
    major     = steep_r ? ady_r : dx_r;
    d_pos     = (d_r > 0);
    if (cmd.load) begin
      x_nxt     = x0;
      y_nxt     = y0;
      dx_nxt    = sdx;
      ady_nxt   = sady;
      steep_nxt = ssteep;
      yneg_nxt  = sneg;
      cnt_nxt   = ssteep ? sady : sdx;
      d_nxt     = ssteep ? ((sx(sdx) <<< 1) - sx(sady)) : ((sx(sady) <<< 1) - sx(sdx));
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - 1'b1;
      if (d_pos) begin
        d_nxt = d_r + ((sx(minor) - sx(major)) <<< 1);
      end else begin
        d_nxt = d_r + (sx(minor) <<< 1);
      end
      if (!steep_r || d_pos) begin
        x_nxt = x_r + 1'b1;
      end
      if (steep_r || d_pos) begin
        y_nxt = yneg_r ? (y_r - 1'b1) : (y_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    dx_r    <= dx_nxt;
    ady_r   <= ady_nxt;
    cnt_r   <= cnt_nxt;
    d_r     <= d_nxt;
    steep_r <= steep_nxt;
    yneg_r  <= yneg_nxt;
  end

  // Capture the current pixel into the output register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      px_r    <= x_r;
      py_r    <= y_r;
      plast_r <= (cnt_r == '0);
    end
  end

  assign out_tdata = {{(OUT_TDATA_W - 2 * CW){1'b0}}, py_r, px_r};
  assign out_tlast = plast_r;

endmodule
`default_nettype wire

// File: design/line_rasterizer.sv
// Top level of the midpoint line rasterizer.
// The first pixel beat is registered: the segment is latched into the stepping state, and a
// step then moves the pixel into the output register. Throughput: one pixel per cycle while
// out_tready does not stall it; a segment holds the input until its final pixel is moved out.
// The next segment is taken while the final pixel still waits in the output register.
// Reset (synchronous, rst_n low) empties the output register and returns to idle.
`timescale 1ns / 1ps
`default_nettype none
module line_rasterizer #(
  parameter int GRID_SIZE = lr_pkg::GRID_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18]
  input  wire logic [lr_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // pixel_x[5:0], pixel_y[11:6], zeros above
  output logic [lr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);
  import lr_pkg::*;

  lr_cmd_t  cmd;
  lr_stat_t stat;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lr_dp #(
    .GRID_SIZE(GRID_SIZE)
  ) u_dp (
    .clk      (clk),
    .in_tdata (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the line rasterizer: segment stimulus, pixel scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int CW          = lr_pkg::CW;
  localparam int GRID        = lr_pkg::GRID_SIZE_DEF;
  localparam int RAND_ITEMS  = 350;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_WAIT  = 20;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } pixel_t;

  // Expected pixel stream, built from each segment beat the block takes
  class pixel_scoreboard;
    pixel_t pending_pixels[$];
    int     errors;
    int     checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    task report(input string what);
      $display("MISMATCH @%0t pixel %0d: %s", $realtime, checked, what);
      errors++;
    endtask

    function int clamp_coord(input logic [CW-1:0] v);
      int c;
      c = int'(v);
      if (c > GRID - 1) c = GRID - 1;
      return c;
    endfunction

    // Walk the midpoint line and queue every pixel it lights
    function void note_segment(input logic [lr_pkg::IN_TDATA_W-1:0] seg);
      int     xa, ya, xb, yb, t;
      int     dx, dy, ady, ystep, dv, n, x, y, k;
      bit     steep;
      pixel_t p;
      xa = clamp_coord(seg[CW-1:0]);
      ya = clamp_coord(seg[2*CW-1:CW]);
      xb = clamp_coord(seg[3*CW-1:2*CW]);
      yb = clamp_coord(seg[4*CW-1:3*CW]);
      // swap so x never falls
      if (xa > xb) begin
        t = xa; xa = xb; xb = t;
        t = ya; ya = yb; yb = t;
      end
      dx    = xb - xa;
      dy    = yb - ya;
      ady   = (dy < 0) ? -dy : dy;
      ystep = (dy < 0) ? -1 : 1;
      steep = (ady > dx);
      n     = steep ? ady + 1 : dx + 1;
      dv    = steep ? 2 * dx - ady : 2 * ady - dx;
      x     = xa;
      y     = ya;
      for (k = 0; k < n; k++) begin
        p.x    = x[CW-1:0];
        p.y    = y[CW-1:0];
        p.last = (k == n - 1);
        pending_pixels.push_back(p);
        if (steep) begin
          if (dv <= 0) begin
            dv += 2 * dx;
          end else begin
            dv += 2 * (dx - ady);
            x++;
          end
          y += ystep;
        end else begin
          if (dv <= 0) begin
            dv += 2 * ady;
          end else begin
            dv += 2 * (ady - dx);
            y += ystep;
          end
          x++;
        end
      end
    endfunction

    // Compare one output beat with the oldest expected pixel
    task check_pixel(input logic [lr_pkg::OUT_TDATA_W-1:0] data, input logic last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected beat x=%0d y=%0d last=%0b",
                         data[CW-1:0], data[2*CW-1:CW], last));
      end else begin
        want = pending_pixels.pop_front();
        if (data[CW-1:0] !== want.x)
          report($sformatf("x got %0d want %0d", data[CW-1:0], want.x));
        if (data[2*CW-1:CW] !== want.y)
          report($sformatf("y got %0d want %0d", data[2*CW-1:CW], want.y));
        if (last !== want.last)
          report($sformatf("last got %0b want %0b", last, want.last));
        if (data[lr_pkg::OUT_TDATA_W-1:2*CW] !== '0)
          report($sformatf("padding got %0h", data[lr_pkg::OUT_TDATA_W-1:2*CW]));
      end
      checked++;
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18]
  logic [lr_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  // pixel_x[5:0], pixel_y[11:6], zeros above
  logic [lr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                          out_tlast;

  pixel_scoreboard pixel_board;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              hold_request;
  int              cycle_count;

  line_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check every pixel beat taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pixel_board.check_pixel(out_tdata, out_tlast);
  end

  // Drive the receiver: random back-pressure plus a long hold when asked
  initial begin : receiver
    int hold_left;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [lr_pkg::IN_TDATA_W-1:0] seg(input int sx, sy, ex, ey);
    logic [CW-1:0] a, b, c, d;
    a = sx[CW-1:0];
    b = sy[CW-1:0];
    c = ex[CW-1:0];
    d = ey[CW-1:0];
    return {d, c, b, a};
  endfunction

  function automatic int near_coord(input int base);
    int v;
    v = base + $urandom_range(8) - 4;
    if (v < 0) v = 0;
    if (v > GRID - 1) v = GRID - 1;
    return v;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(2))
      0: return 0;
      1: return GRID - 1;
      default: return $urandom_range(GRID - 1);
    endcase
  endfunction

  // Mix of full-range, short, axis-aligned, diagonal and grid-edge segments
  function automatic logic [lr_pkg::IN_TDATA_W-1:0] random_segment();
    int sx, sy, ex, ey, len;
    sx = $urandom_range(GRID - 1);
    sy = $urandom_range(GRID - 1);
    ex = $urandom_range(GRID - 1);
    ey = $urandom_range(GRID - 1);
    case ($urandom_range(9))
      4, 5, 6: begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end
      7: begin
        if ($urandom_range(1)) ey = sy;
        else ex = sx;
      end
      8: begin
        len = $urandom_range(GRID - 1);
        ex  = (sx + len > GRID - 1) ? sx - len : sx + len;
        ey  = (sy + len > GRID - 1) ? sy - len : sy + len;
        if (ex < 0) ex = 0;
        if (ey < 0) ey = 0;
      end
      9: begin
        sx = edge_coord();
        sy = edge_coord();
        ex = edge_coord();
        ey = edge_coord();
      end
      default: ;
    endcase
    return seg(sx, sy, ex, ey);
  endfunction

  // Offer one segment beat, with random idle cycles ahead of it
  task send_segment(input logic [lr_pkg::IN_TDATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    pixel_board.note_segment(data);
  endtask

  task wait_drained();
    while (pixel_board.pending_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase, i;
    pixel_board   = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single points, grid edges, all octants, reversal, ties
    send_idle_pct = 16;
    recv_idle_pct = 71;
    send_segment(seg(0, 0, 0, 0));
    send_segment(seg(63, 63, 63, 63));
    send_segment(seg(0, 0, 63, 0));
    send_segment(seg(63, 63, 0, 63));
    send_segment(seg(0, 0, 0, 63));
    send_segment(seg(0, 63, 0, 0));
    send_segment(seg(0, 0, 63, 63));
    send_segment(seg(63, 63, 0, 0));
    send_segment(seg(0, 63, 63, 0));
    send_segment(seg(63, 0, 0, 63));
    send_segment(seg(0, 0, 63, 10));
    send_segment(seg(0, 50, 63, 40));
    send_segment(seg(5, 60, 10, 0));
    send_segment(seg(12, 2, 20, 61));
    send_segment(seg(50, 10, 3, 20));
    send_segment(seg(40, 5, 30, 55));
    send_segment(seg(0, 0, 2, 1));
    send_segment(seg(0, 0, 1, 2));
    send_segment(seg(10, 10, 14, 8));
    send_segment(seg(30, 30, 28, 34));
    send_segment(seg(10, 10, 11, 10));
    send_segment(seg(21, 42, 21, 41));

    // Random: three idle profiles, with two long output holds and one full drain
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 16; recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (i = 0; i < RAND_ITEMS / 3; i++) begin
        if (phase == 0 && i == 40) hold_request = LONG_HOLD;
        if (phase == 2 && i == 20) hold_request = LONG_HOLD;
        if (phase == 1 && i == 60) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
        send_segment(random_segment());
      end
    end
    in_tvalid <= 1'b0;

    // Drain and let any stray beat show up
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pixel_board.pending_pixels.size() != 0)
      pixel_board.report($sformatf("%0d pixels never arrived",
                                   pixel_board.pending_pixels.size()));
    if (pixel_board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
